### rtl/core/lbct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU block cache tag engine.
// No dependencies; used by lru_block_cache_tags in rtl/core.
package lbct_pkg;

   localparam int LINE_W  = 6;
   localparam int DISK_W  = 8;
   localparam int BLOCK_W = 32;
   localparam int STAMP_W = 32;

   // request kinds
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [DISK_W-1:0]  disk_id;
      logic [BLOCK_W-1:0] block_id;
   } req_beat_type;

   typedef struct packed {
      logic               hit;
      logic [LINE_W-1:0]  line;
      logic               found;
      logic               evicted;
      logic [DISK_W-1:0]  victim_disk;
      logic [BLOCK_W-1:0] victim_block;
   } rsp_beat_type;

   // one line of the tag store
   typedef struct packed {
      logic [DISK_W-1:0]  disk_tag;
      logic [BLOCK_W-1:0] block_tag;
      logic [STAMP_W-1:0] use_stamp;
   } tag_entry_type;

   localparam int ENTRY_W = $bits(tag_entry_type);

endpackage

### rtl/core/lbct_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lbct_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lru_block_cache_tags.sv
`timescale 1ns / 1ps
// Top level of the LRU block cache tag engine.
// Depends on lbct_pkg and lbct_ram.

// Tag and replacement engine of a fully associative cache of LINES lines keyed
// by (disk_id, block_id). A get beat looks the key up and refreshes a hit line;
// a put beat refreshes a hit line, otherwise fills the lowest empty line or
// evicts the least recently used one and reports the victim key. Block
// payloads live outside, addressed by the returned line number (low 6 bits
// of the line index). Tags and use stamps sit in one RAM that a single
// compare/age unit sweeps one line per cycle. Lines fill strictly in order
// and are never invalidated, so a fill count stands in for the valid bits
// and no clearing pass runs after reset. A request runs from accept through
// the sweep of the filled lines and the finish state to the result register.
// req_stall is high from accept until the result moves to the rsp register;
// a finished result waits in the rsp register without holding the next sweep,
// but that next result holds in its output state (input stalled) until the
// rsp register is free.
module lru_block_cache_tags #(
   parameter int LINES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lbct_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lbct_pkg::rsp_beat_type rsp_beat
);

   localparam int IW = $clog2(LINES);       // line index width
   localparam int FW = $clog2(LINES + 1);   // fill count width
   localparam logic [FW-1:0] FULL = FW'(LINES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_OUT
   } state_type;

   // control
   state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [lbct_pkg::STAMP_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   // request and sweep results
   lbct_pkg::req_beat_type key_ff, key_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in;
   logic [IW-1:0] hit_line_ff, hit_line_in;
   logic have_old_ff, have_old_in;
   logic [lbct_pkg::STAMP_W-1:0] old_age_ff, old_age_in;
   logic [IW-1:0] old_line_ff, old_line_in;
   logic [lbct_pkg::DISK_W-1:0] old_disk_ff, old_disk_in;
   logic [lbct_pkg::BLOCK_W-1:0] old_block_ff, old_block_in;
   lbct_pkg::rsp_beat_type res_ff, res_in;
   lbct_pkg::rsp_beat_type rsp_ff, rsp_in;

   // tag RAM
   logic ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   lbct_pkg::tag_entry_type ram_wdata, ram_rdata;

   // sweep unit
   logic [lbct_pkg::STAMP_W-1:0] age;
   logic key_match;
   logic last_line;

   // finish
   logic [IW-1:0] tgt;
   logic [IW+5:0] tgt_ext;
   logic is_put;
   logic full;

   lbct_ram #(
      .WIDTH(lbct_pkg::ENTRY_W),
      .DEPTH(LINES)
   ) u_tags (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // sweep: line idx_ff is on the RAM output during ST_SCAN
   assign ram_raddr = (state_ff == ST_SCAN) ? IW'(idx_ff + 1'b1) : '0;
   assign age       = count_ff - ram_rdata.use_stamp;
   assign key_match = (ram_rdata.disk_tag == key_ff.disk_id) &&
                      (ram_rdata.block_tag == key_ff.block_id);
   assign last_line = ((FW'(idx_ff) + FW'(1)) == fill_ff);

   assign is_put  = (key_ff.req_type == lbct_pkg::REQ_PUT);
   assign full    = (fill_ff == FULL);
   assign tgt     = hit_ff ? hit_line_ff : (full ? old_line_ff : fill_ff[IW-1:0]);
   assign tgt_ext = (IW + 6)'(tgt);

   assign ram_we    = (state_ff == ST_FINISH) && (hit_ff || is_put);
   assign ram_waddr = tgt;
   assign ram_wdata = '{disk_tag: key_ff.disk_id, block_tag: key_ff.block_id,
                        use_stamp: count_ff};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_line_in  = hit_line_ff;
      have_old_in  = have_old_ff;
      old_age_in   = old_age_ff;
      old_line_in  = old_line_ff;
      old_disk_in  = old_disk_ff;
      old_block_in = old_block_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in      = req_beat;
               idx_in      = '0;
               hit_in      = 1'b0;
               hit_line_in = '0;
               have_old_in = 1'b0;
               old_age_in  = '0;
               old_line_in = '0;
               state_in    = (fill_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!hit_ff && key_match) begin
               hit_in      = 1'b1;
               hit_line_in = idx_ff;
            end
            // strictly older wins, so ties keep the lower line
            if (!have_old_ff || (age > old_age_ff)) begin
               have_old_in  = 1'b1;
               old_age_in   = age;
               old_line_in  = idx_ff;
               old_disk_in  = ram_rdata.disk_tag;
               old_block_in = ram_rdata.block_tag;
            end
            idx_in = IW'(idx_ff + 1'b1);
            if (last_line) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_in.hit          = hit_ff;
            res_in.found        = hit_ff || is_put;
            res_in.line         = (hit_ff || is_put) ? tgt_ext[5:0] : '0;
            res_in.evicted      = !hit_ff && is_put && full;
            res_in.victim_disk  = (!hit_ff && is_put && full) ? old_disk_ff : '0;
            res_in.victim_block = (!hit_ff && is_put && full) ? old_block_ff : '0;
            if (!hit_ff && is_put && !full) begin
               fill_in = fill_ff + 1'b1;
            end
            count_in = count_ff + 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_line_ff  <= hit_line_in;
      have_old_ff  <= have_old_in;
      old_age_ff   <= old_age_in;
      old_line_ff  <= old_line_in;
      old_disk_ff  <= old_disk_in;
      old_block_ff <= old_block_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond line count");

   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (FW'(idx_ff) < fill_ff))
      else $error("sweep past filled lines");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a beat while idle afterwards");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.evicted) |-> (full && rsp_ff.found && !rsp_ff.hit))
      else $error("eviction without a full cache");

   a_hit_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> rsp_ff.found)
      else $error("hit without found");
`endif

endmodule
